>>> design/kss_pkg.sv
// ----------------------------------------------------------------------------
// kss_pkg
// Shared codes and constants of the k-th smallest select block.
// ----------------------------------------------------------------------------
`default_nettype none

package kss_pkg;

  localparam int CMD_W    = 2;
  localparam int VALUE_W  = 32;
  localparam int RANK_W   = 8;
  localparam int STATUS_W = 2;

  // request kinds carried on in_tuser
  localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SELECT = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

  // result status carried on out_tuser
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  // pivot generator: Galois LFSR, right shift
  localparam int              LFSR_W    = 16;
  localparam logic [LFSR_W-1:0] LFSR_SEED = 16'hACE1;
  localparam logic [LFSR_W-1:0] LFSR_TAPS = 16'hB400;

endpackage

`default_nettype wire

>>> design/kss_store.sv
// ----------------------------------------------------------------------------
// kss_store
// Key memory: one write port and two registered read ports.
// ----------------------------------------------------------------------------
`default_nettype none

module kss_store #(
  parameter int DEPTH    = 256,
  parameter int KEY_BITS = 32,
  parameter int AW       = 8
) (
  input  wire logic                clk,
  input  wire logic                rd_en,
  input  wire logic [AW-1:0]       rd_addr_a,
  input  wire logic [AW-1:0]       rd_addr_b,
  output logic      [KEY_BITS-1:0] rd_data_a,
  output logic      [KEY_BITS-1:0] rd_data_b,
  input  wire logic                wr_en,
  input  wire logic [AW-1:0]       wr_addr,
  input  wire logic [KEY_BITS-1:0] wr_data
);

  logic [KEY_BITS-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // hold read data until the next read so swaps can use it over two writes
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
    end
  end

endmodule

`default_nettype wire

>>> design/kss_mod_unit.sv
// ----------------------------------------------------------------------------
// kss_mod_unit
// Bit-serial remainder of the LFSR word by the window span, one bit a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module kss_mod_unit
  import kss_pkg::*;
#(
  parameter int DIV_W = 9
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [LFSR_W-1:0] dividend,
  input  wire logic [DIV_W-1:0]  divisor,
  output logic                   done,
  output logic      [DIV_W-1:0]  remainder
);

  localparam int CNT_W = $clog2(LFSR_W);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [LFSR_W-1:0] dvd_r, dvd_nxt;
  logic [DIV_W-1:0]  dvs_r, dvs_nxt;
  logic [DIV_W-1:0]  rem_r, rem_nxt;
  logic [DIV_W:0]    trial;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    dvs_nxt  = dvs_r;
    rem_nxt  = rem_r;
    trial    = {rem_r, dvd_r[LFSR_W-1]};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      dvd_nxt  = dividend;
      dvs_nxt  = divisor;
      rem_nxt  = '0;
    end else if (busy_r) begin
      // shift in the next dividend bit, subtract when it fits
      dvd_nxt = {dvd_r[LFSR_W-2:0], 1'b0};
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = DIV_W'(trial - {1'b0, dvs_r});
      end else begin
        rem_nxt = trial[DIV_W-1:0];
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(LFSR_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    dvs_r <= dvs_nxt;
    rem_r <= rem_nxt;
  end

  assign done      = done_r;
  assign remainder = rem_r;

endmodule

`default_nettype wire

>>> design/kth_smallest_select.sv
// ----------------------------------------------------------------------------
// kth_smallest_select
// Key store with order-statistic select by randomized quickselect.
// ----------------------------------------------------------------------------
// Requests arrive on the in_ stream: in_tuser is the command (load, select,
// clear), in_tdata carries the key and the rank. Results leave on the out_
// stream with the key in out_tdata and the status in out_tuser.
// A load or a clear is taken without leaving the idle state; a load result
// is registered and shows on the next cycle. A select out of range answers
// the same way. A select in range runs partition rounds over the key memory:
// each round waits on the bit-serial remainder that places the pivot, then
// handles each key in the window at a pace bounded by the single memory
// write port used for the swaps. in_tready is low while a select runs.
// Reset empties the store and reseeds the pivot LFSR; the memory itself is
// not cleared. When the receiver stalls, the result waits in the output
// register; one new request may be taken meanwhile only in the cycle the
// waiting result is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module kth_smallest_select
  import kss_pkg::*;
#(
  parameter int DEPTH    = 256,
  parameter int KEY_BITS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [39:0] in_tdata,   // [31:0] value, [39:32] rank
  input  wire logic [1:0]  in_tuser,   // [1:0] command
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // [31:0] selected_value
  output logic [1:0]       out_tuser   // [1:0] status
);

  localparam int AW    = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  typedef enum logic [12:0] {
    S_IDLE   = 13'b0000000000001,
    S_ROUND  = 13'b0000000000010,
    S_MOD    = 13'b0000000000100,
    S_PV_RD  = 13'b0000000001000,
    S_PV_W1  = 13'b0000000010000,
    S_PV_W2  = 13'b0000000100000,
    S_RD     = 13'b0000001000000,
    S_CMP    = 13'b0000010000000,
    S_WR2    = 13'b0000100000000,
    S_FIN_RD = 13'b0001000000000,
    S_FIN_W1 = 13'b0010000000000,
    S_FIN_W2 = 13'b0100000000000,
    S_GET    = 13'b1000000000000
  } state_t;

  state_t              state_r, state_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [LFSR_W-1:0]   lfsr_r, lfsr_nxt;
  logic [AW-1:0]       k_r, k_nxt;
  logic [AW-1:0]       lo_r, lo_nxt;
  logic [AW-1:0]       hi_r, hi_nxt;
  logic [AW-1:0]       p_r, p_nxt;
  logic [AW-1:0]       j_r, j_nxt;
  logic [AW-1:0]       fill_r, fill_nxt;
  logic [KEY_BITS-1:0] pivot_r, pivot_nxt;
  logic                get_out_r, get_out_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [31:0]         out_value_r, out_value_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;

  logic                accept;
  logic [CMD_W-1:0]    in_cmd;
  logic [RANK_W-1:0]   in_rank;
  logic signed [VALUE_W-1:0] in_value;
  logic signed [63:0]  value_ext;
  logic signed [KEY_BITS-1:0] out_key;
  logic signed [63:0]  out_key_ext;
  logic                key_le;
  logic [AW-1:0]       j_inc;
  logic [AW-1:0]       q;

  logic                rd_en;
  logic [AW-1:0]       rd_addr_a, rd_addr_b;
  logic [KEY_BITS-1:0] rd_data_a, rd_data_b;
  logic                wr_en;
  logic [AW-1:0]       wr_addr;
  logic [KEY_BITS-1:0] wr_data;

  logic                mod_start;
  logic                mod_done;
  logic [CNT_W-1:0]    mod_rem;
  logic [CNT_W-1:0]    span;

  assign in_cmd    = in_tuser;
  assign in_value  = signed'(in_tdata[31:0]);
  assign in_rank   = in_tdata[39:32];
  assign value_ext = 64'(in_value);
  assign in_tready = (state_r == S_IDLE) && (!out_valid_r || out_tready);
  assign accept    = in_tvalid && in_tready;

  assign out_key     = signed'(rd_data_a);
  assign out_key_ext = 64'(out_key);
  assign key_le      = signed'(rd_data_a) <= signed'(pivot_r);
  assign j_inc       = j_r + 1'b1;
  assign q           = fill_r;
  assign span        = CNT_W'(CNT_W'(hi_r) - CNT_W'(lo_r) + 1'b1);

  kss_store #(
    .DEPTH    (DEPTH),
    .KEY_BITS (KEY_BITS),
    .AW       (AW)
  ) u_store (
    .clk       (clk),
    .rd_en     (rd_en),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .rd_data_a (rd_data_a),
    .rd_data_b (rd_data_b),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data)
  );

  kss_mod_unit #(
    .DIV_W (CNT_W)
  ) u_mod (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (mod_start),
    .dividend  (lfsr_r),
    .divisor   (span),
    .done      (mod_done),
    .remainder (mod_rem)
  );

  // memory port steering
  always_comb begin
    rd_en     = 1'b0;
    rd_addr_a = j_r;
    rd_addr_b = fill_r;
    wr_en     = 1'b0;
    wr_addr   = fill_r;
    wr_data   = rd_data_a;
    case (state_r)
      S_IDLE: begin
        wr_en   = accept && (in_cmd == CMD_LOAD) && (count_r != CNT_W'(DEPTH));
        wr_addr = count_r[AW-1:0];
        wr_data = value_ext[KEY_BITS-1:0];
      end
      S_PV_RD: begin
        rd_en     = 1'b1;
        rd_addr_a = p_r;
        rd_addr_b = hi_r;
      end
      S_PV_W1: begin
        wr_en   = 1'b1;
        wr_addr = p_r;
        wr_data = rd_data_b;
      end
      S_PV_W2: begin
        wr_en   = 1'b1;
        wr_addr = hi_r;
        wr_data = rd_data_a;
      end
      S_RD: begin
        rd_en = 1'b1;
      end
      S_CMP: begin
        wr_en = key_le && (fill_r != j_r);
      end
      S_WR2: begin
        wr_en   = 1'b1;
        wr_addr = j_r;
        wr_data = rd_data_b;
      end
      S_FIN_RD: begin
        rd_en     = 1'b1;
        rd_addr_a = fill_r;
        rd_addr_b = hi_r;
      end
      S_FIN_W1: begin
        wr_en   = 1'b1;
        wr_addr = fill_r;
        wr_data = rd_data_b;
      end
      S_FIN_W2: begin
        wr_en   = 1'b1;
        wr_addr = hi_r;
        wr_data = rd_data_a;
      end
      S_GET: begin
        rd_en     = !get_out_r;
        rd_addr_a = k_r;
        rd_addr_b = k_r;
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    lfsr_nxt       = lfsr_r;
    k_nxt          = k_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    p_nxt          = p_r;
    j_nxt          = j_r;
    fill_nxt       = fill_r;
    pivot_nxt      = pivot_r;
    get_out_nxt    = 1'b0;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_value_nxt  = out_value_r;
    out_status_nxt = out_status_r;
    mod_start      = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_cmd)
            CMD_LOAD: begin
              out_valid_nxt = 1'b1;
              out_value_nxt = '0;
              if (count_r == CNT_W'(DEPTH)) begin
                out_status_nxt = ST_FULL;
              end else begin
                out_status_nxt = ST_OK;
                count_nxt      = count_r + 1'b1;
              end
            end
            CMD_SELECT: begin
              if (32'(in_rank) < 32'(count_r)) begin
                k_nxt     = AW'(in_rank);
                lo_nxt    = '0;
                hi_nxt    = AW'(count_r - 1'b1);
                state_nxt = S_ROUND;
              end else begin
                out_valid_nxt  = 1'b1;
                out_value_nxt  = '0;
                out_status_nxt = ST_RANGE;
              end
            end
            CMD_CLEAR: begin
              count_nxt = '0;
            end
            default: begin
              count_nxt = count_r;
            end
          endcase
        end
      end
      S_ROUND: begin
        if (lo_r >= hi_r) begin
          state_nxt = S_GET;
        end else begin
          mod_start = 1'b1;
          lfsr_nxt  = (lfsr_r >> 1) ^ (lfsr_r[0] ? LFSR_TAPS : '0);
          state_nxt = S_MOD;
        end
      end
      S_MOD: begin
        if (mod_done) begin
          p_nxt     = lo_r + AW'(mod_rem);
          state_nxt = S_PV_RD;
        end
      end
      S_PV_RD: begin
        state_nxt = S_PV_W1;
      end
      S_PV_W1: begin
        pivot_nxt = rd_data_a;
        state_nxt = S_PV_W2;
      end
      S_PV_W2: begin
        j_nxt     = lo_r;
        fill_nxt  = lo_r;
        state_nxt = S_RD;
      end
      S_RD: begin
        state_nxt = S_CMP;
      end
      S_CMP: begin
        if (key_le) begin
          fill_nxt = fill_r + 1'b1;
        end
        if (key_le && (fill_r != j_r)) begin
          state_nxt = S_WR2;
        end else begin
          j_nxt     = j_inc;
          state_nxt = (j_inc == hi_r) ? S_FIN_RD : S_RD;
        end
      end
      S_WR2: begin
        j_nxt     = j_inc;
        state_nxt = (j_inc == hi_r) ? S_FIN_RD : S_RD;
      end
      S_FIN_RD: begin
        state_nxt = S_FIN_W1;
      end
      S_FIN_W1: begin
        state_nxt = S_FIN_W2;
      end
      S_FIN_W2: begin
        // narrow to the side holding the rank
        if (k_r == q) begin
          state_nxt = S_GET;
        end else if (k_r < q) begin
          hi_nxt    = q - 1'b1;
          state_nxt = S_ROUND;
        end else begin
          lo_nxt    = q + 1'b1;
          state_nxt = S_ROUND;
        end
      end
      S_GET: begin
        if (!get_out_r) begin
          get_out_nxt = 1'b1;
        end else begin
          out_valid_nxt  = 1'b1;
          out_value_nxt  = out_key_ext[31:0];
          out_status_nxt = ST_OK;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      lfsr_r      <= LFSR_SEED;
      get_out_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      lfsr_r      <= lfsr_nxt;
      get_out_r   <= get_out_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r          <= k_nxt;
    lo_r         <= lo_nxt;
    hi_r         <= hi_nxt;
    p_r          <= p_nxt;
    j_r          <= j_nxt;
    fill_r       <= fill_nxt;
    pivot_r      <= pivot_nxt;
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_value_r;
  assign out_tuser  = out_status_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("entry count beyond store depth");

  a_lfsr_live: assert property (@(posedge clk) disable iff (!rst_n)
    lfsr_r != '0)
    else $error("pivot lfsr reached zero");

  a_scan_window: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CMP |-> (fill_r <= j_r) && (j_r < hi_r) && (lo_r <= j_r))
    else $error("partition scan left its window");

  a_pivot_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_PV_RD |-> (p_r >= lo_r) && (p_r <= hi_r))
    else $error("pivot index outside window");

  a_select_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_IDLE |-> !in_tready && (!out_valid_r || state_r == S_GET))
    else $error("request taken or result pending during select");

endmodule

`default_nettype wire
